>>> hw/rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants, widths and the arctangent table for the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

	// Number of CORDIC vectoring iterations, one pipeline stage each.
	localparam int CORDIC_STEPS = 16;

	// Widths of the input components, products, vectors and angles.
	localparam int QW  = 32;
	localparam int PW  = 34;
	localparam int CW  = 40;
	localparam int ZW  = 34;
	localparam int OFW = 12;
	localparam int AW  = 16;
	localparam int KW  = 30;

	// Integer square root runs one result bit per stage.
	localparam int SQ_STAGES = 32;

	localparam logic signed [CW-1:0] ONE_Q30  = 40'sd1073741824;
	localparam logic signed [ZW-1:0] PI_Q30   = 34'sd3373259426;
	localparam logic signed [KW-1:0] DEG128_K = 30'sd480667238;

	// Configuration register indexes.
	localparam logic [1:0] REG_PITCH_OFS = 2'd0;
	localparam logic [1:0] REG_ROLL_OFS  = 2'd1;
	localparam logic [1:0] REG_YAW_OFS   = 2'd2;

	// Channel order inside the per-axis arrays.
	localparam int CH_PITCH = 0;
	localparam int CH_ROLL  = 1;
	localparam int CH_YAW   = 2;

	typedef logic signed [CW-1:0] vec_t;
	typedef logic signed [ZW-1:0] ang_t;

	// Arctangent of 2^-i in Q30 radians, rounded to nearest.
	function automatic logic [ZW-1:0] atan_step(input int i);
		logic [ZW-1:0] r;
		case (i)
			0: r = 34'd843314857;
			1: r = 34'd497837829;
			2: r = 34'd263043836;
			3: r = 34'd133525158;
			4: r = 34'd67021687;
			5: r = 34'd33543516;
			6: r = 34'd16775851;
			7: r = 34'd8388437;
			8: r = 34'd4194283;
			9: r = 34'd2097149;
			default: r = (i <= 30) ? (ZW'(1) << (30 - i)) : '0;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/qte_quat_if.sv
// ----------------------------------------------------------------------------
// qte_quat_if
// Request channel carrying one quaternion sample in Q30.
// ----------------------------------------------------------------------------
interface qte_quat_if;
	logic                valid;
	logic                ready;
	logic                quat_present;
	logic signed [31:0]  quat_w;
	logic signed [31:0]  quat_x;
	logic signed [31:0]  quat_y;
	logic signed [31:0]  quat_z;

	modport source (output valid, quat_present, quat_w, quat_x, quat_y, quat_z,
		input ready);
	modport sink (input valid, quat_present, quat_w, quat_x, quat_y, quat_z,
		output ready);
endinterface

>>> hw/rtl/qte_angle_if.sv
// ----------------------------------------------------------------------------
// qte_angle_if
// Request channel carrying one set of Euler angles in 1/128 degree.
// ----------------------------------------------------------------------------
interface qte_angle_if;
	logic                valid;
	logic                ready;
	logic signed [15:0]  pitch_angle;
	logic signed [15:0]  roll_angle;
	logic signed [15:0]  yaw_angle;

	modport source (output valid, pitch_angle, roll_angle, yaw_angle, input ready);
	modport sink (input valid, pitch_angle, roll_angle, yaw_angle, output ready);
endinterface

>>> hw/rtl/qte_cfg_if.sv
// ----------------------------------------------------------------------------
// qte_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface qte_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [11:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/quaternion_to_euler_angles.sv
// Throughput: one sample per cycle; the 32-stage square root and the CORDIC
// stages are fully pipelined, and the pipeline only holds while the output
// register waits for its request to be taken.
// Reset clears all valid bits and sets the three offset registers to zero.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Converts a Q30 unit quaternion into Z-Y-X pitch, roll and yaw angles using
// pipelined products, a pipelined square root and three CORDIC arctangents.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles (
	input  logic clk,
	input  logic arst_n,
	qte_quat_if.sink    quat_in,
	qte_angle_if.source angle_out,
	qte_cfg_if.sink     cfg
);
	import qte_pkg::*;

	// Whole pipeline moves when the output register is free or being taken.
	logic adv;
	logic out_valid_q;
	assign adv = !out_valid_q || angle_out.ready;
	assign quat_in.ready = adv;

	// Offset registers.
	logic signed [OFW-1:0] ofs_q [3];
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_q[0] <= '0;
			ofs_q[1] <= '0;
			ofs_q[2] <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PITCH_OFS: ofs_q[CH_PITCH] <= cfg.data;
				REG_ROLL_OFS:  ofs_q[CH_ROLL]  <= cfg.data;
				REG_YAW_OFS:   ofs_q[CH_YAW]   <= cfg.data;
				default: ;
			endcase
		end
	end

	// Q30 product with floor rounding.
	function automatic logic signed [PW-1:0] mulq(input logic signed [QW-1:0] a,
		input logic signed [QW-1:0] b);
		logic signed [63:0] p;
		p = a * b;
		return p[PW+29:30];
	endfunction

	// Stage 1: component products.
	logic valid_s1;
	logic signed [PW-1:0] wb_s1, ac_s1, bc_s1, wa_s1, aa_s1, bb_s1, ab_s1, wc_s1;
	logic signed [PW-1:0] ww_s1, cc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= quat_in.valid && quat_in.quat_present;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wb_s1 <= mulq(quat_in.quat_w, quat_in.quat_y);
			ac_s1 <= mulq(quat_in.quat_x, quat_in.quat_z);
			bc_s1 <= mulq(quat_in.quat_y, quat_in.quat_z);
			wa_s1 <= mulq(quat_in.quat_w, quat_in.quat_x);
			aa_s1 <= mulq(quat_in.quat_x, quat_in.quat_x);
			bb_s1 <= mulq(quat_in.quat_y, quat_in.quat_y);
			ab_s1 <= mulq(quat_in.quat_x, quat_in.quat_y);
			wc_s1 <= mulq(quat_in.quat_w, quat_in.quat_z);
			ww_s1 <= mulq(quat_in.quat_w, quat_in.quat_w);
			cc_s1 <= mulq(quat_in.quat_z, quat_in.quat_z);
		end
	end

	// Stage 2: sums forming the roll and yaw vectors and the clamped pitch argument.
	logic valid_s2;
	logic signed [31:0] ps_s2;
	vec_t ry_s2, rx_s2, yy_s2, yx_s2;
	vec_t s_raw;

	assign s_raw = (vec_t'(wb_s1) - vec_t'(ac_s1)) <<< 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (s_raw > ONE_Q30) begin
				ps_s2 <= ONE_Q30[31:0];
			end else if (s_raw < -ONE_Q30) begin
				ps_s2 <= 32'(-ONE_Q30);
			end else begin
				ps_s2 <= s_raw[31:0];
			end
			ry_s2 <= (vec_t'(bc_s1) + vec_t'(wa_s1)) <<< 1;
			rx_s2 <= ONE_Q30 - ((vec_t'(aa_s1) + vec_t'(bb_s1)) <<< 1);
			yy_s2 <= (vec_t'(ab_s1) + vec_t'(wc_s1)) <<< 1;
			yx_s2 <= vec_t'(ww_s1) + vec_t'(aa_s1) - vec_t'(bb_s1) - vec_t'(cc_s1);
		end
	end

	// Stage 3: radicand (1 - s)(1 + s) for the pitch cosine.
	logic valid_s3;
	logic [63:0] rad_s3;
	logic signed [31:0] ps_s3;
	vec_t ry_s3, rx_s3, yy_s3, yx_s3;
	logic [31:0] one_m, one_p;

	assign one_m = 32'(ONE_Q30 - vec_t'(ps_s2));
	assign one_p = 32'(ONE_Q30 + vec_t'(ps_s2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s3 <= 64'(one_m) * 64'(one_p);
			ps_s3  <= ps_s2;
			ry_s3  <= ry_s2;
			rx_s3  <= rx_s2;
			yy_s3  <= yy_s2;
			yx_s3  <= yx_s2;
		end
	end

	// Square root stages, one result bit each; row 0 is stage 3.
	logic        vld_sk [0:SQ_STAGES];
	logic [63:0] rem_sk [0:SQ_STAGES];
	logic [63:0] root_sk [0:SQ_STAGES];
	logic signed [31:0] ps_sk [0:SQ_STAGES];
	vec_t ry_sk [0:SQ_STAGES];
	vec_t rx_sk [0:SQ_STAGES];
	vec_t yy_sk [0:SQ_STAGES];
	vec_t yx_sk [0:SQ_STAGES];

	assign vld_sk[0]  = valid_s3;
	assign rem_sk[0]  = rad_s3;
	assign root_sk[0] = '0;
	assign ps_sk[0]   = ps_s3;
	assign ry_sk[0]   = ry_s3;
	assign rx_sk[0]   = rx_s3;
	assign yy_sk[0]   = yy_s3;
	assign yx_sk[0]   = yx_s3;

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
		logic [63:0] trial, rem_nx, root_nx;

		always_comb begin
			trial = root_sk[k] + BIT;
			if (rem_sk[k] >= trial) begin
				rem_nx  = rem_sk[k] - trial;
				root_nx = (root_sk[k] >> 1) + BIT;
			end else begin
				rem_nx  = rem_sk[k];
				root_nx = root_sk[k] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k+1] <= 1'b0;
			end else if (adv) begin
				vld_sk[k+1] <= vld_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sk[k+1]  <= rem_nx;
				root_sk[k+1] <= root_nx;
				ps_sk[k+1]   <= ps_sk[k];
				ry_sk[k+1]   <= ry_sk[k];
				rx_sk[k+1]   <= rx_sk[k];
				yy_sk[k+1]   <= yy_sk[k];
				yx_sk[k+1]   <= yx_sk[k];
			end
		end
	end

	// Gather the three input vectors.
	vec_t vy_in [3];
	vec_t vx_in [3];
	assign vy_in[CH_PITCH] = vec_t'(ps_sk[SQ_STAGES]);
	assign vx_in[CH_PITCH] = vec_t'(root_sk[SQ_STAGES][31:0]);
	assign vy_in[CH_ROLL]  = ry_sk[SQ_STAGES];
	assign vx_in[CH_ROLL]  = rx_sk[SQ_STAGES];
	assign vy_in[CH_YAW]   = yy_sk[SQ_STAGES];
	assign vx_in[CH_YAW]   = yx_sk[SQ_STAGES];

	// CORDIC rows; row 0 holds the pre-rotation into the right half plane.
	logic vld_ck [0:CORDIC_STEPS];
	vec_t cx_ck [0:CORDIC_STEPS][3];
	vec_t cy_ck [0:CORDIC_STEPS][3];
	ang_t cz_ck [0:CORDIC_STEPS][3];
	logic zero_ck [0:CORDIC_STEPS][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_ck[0] <= 1'b0;
		end else if (adv) begin
			vld_ck[0] <= vld_sk[SQ_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				zero_ck[0][c] <= (vx_in[c] == '0) && (vy_in[c] == '0);
				if (vx_in[c] < 0) begin
					cx_ck[0][c] <= -vx_in[c];
					cy_ck[0][c] <= -vy_in[c];
					cz_ck[0][c] <= (vy_in[c] >= 0) ? PI_Q30 : -PI_Q30;
				end else begin
					cx_ck[0][c] <= vx_in[c];
					cy_ck[0][c] <= vy_in[c];
					cz_ck[0][c] <= '0;
				end
			end
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		localparam ang_t ATAN_K = $signed(atan_step(k));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_ck[k+1] <= 1'b0;
			end else if (adv) begin
				vld_ck[k+1] <= vld_ck[k];
			end
		end

		// A non-negative y rotates clockwise.
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int c = 0; c < 3; c++) begin
					zero_ck[k+1][c] <= zero_ck[k][c];
					if (cy_ck[k][c] >= 0) begin
						cx_ck[k+1][c] <= cx_ck[k][c] + (cy_ck[k][c] >>> k);
						cy_ck[k+1][c] <= cy_ck[k][c] - (cx_ck[k][c] >>> k);
						cz_ck[k+1][c] <= cz_ck[k][c] + ATAN_K;
					end else begin
						cx_ck[k+1][c] <= cx_ck[k][c] - (cy_ck[k][c] >>> k);
						cy_ck[k+1][c] <= cy_ck[k][c] + (cx_ck[k][c] >>> k);
						cz_ck[k+1][c] <= cz_ck[k][c] - ATAN_K;
					end
				end
			end
		end
	end

	// Scale to 1/128 degree: two partial products over the split angle.
	logic valid_s6, valid_s7;
	logic signed [45:0] phi_s6 [3];
	logic signed [47:0] plo_s6 [3];
	logic signed [17:0] deg_s7 [3];
	ang_t zf [3];
	logic signed [63:0] scaled [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			zf[c] = zero_ck[CORDIC_STEPS][c] ? '0 : cz_ck[CORDIC_STEPS][c];
			scaled[c] = (64'(phi_s6[c]) <<< 17) + 64'(plo_s6[c]) + (64'sd1 <<< 45);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s6 <= vld_ck[CORDIC_STEPS];
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				phi_s6[c] <= 46'($signed(zf[c][ZW-1:17]) * DEG128_K);
				plo_s6[c] <= 48'($signed({1'b0, zf[c][16:0]}) * DEG128_K);
				deg_s7[c] <= scaled[c][63:46];
			end
		end
	end

	// Output register: offset and saturation.
	logic signed [18:0] biased [3];
	logic signed [AW-1:0] ang_q [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			biased[c] = 19'(deg_s7[c]) + 19'(ofs_q[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				if (biased[c] > 19'sd32767) begin
					ang_q[c] <= 16'sh7fff;
				end else if (biased[c] < -19'sd32768) begin
					ang_q[c] <= 16'sh8000;
				end else begin
					ang_q[c] <= biased[c][AW-1:0];
				end
			end
		end
	end

	assign angle_out.valid       = out_valid_q;
	assign angle_out.pitch_angle = ang_q[CH_PITCH];
	assign angle_out.roll_angle  = ang_q[CH_ROLL];
	assign angle_out.yaw_angle   = ang_q[CH_YAW];

endmodule
